/* design/tbt_pkg.sv */
// Shared types, widths and constants of the thermistor temperature block.
package tbt_pkg;

   // Widths of the reading and of the result fraction
   localparam int COUNT_WIDTH = 16;
   localparam int FRACTION_BITS = 8;

   // 5000*high + low and 4999*low - 5000*high
   localparam int AW = COUNT_WIDTH + 13;
   localparam int K5000 = 5000;
   localparam int K4999 = 4999;

   // Logarithm unit
   localparam int LW = (AW > 32) ? AW : 32;
   localparam int KW = $clog2(LW);
   localparam int LOG_W = KW + 32;
   localparam int LOG_LAT = 34;

   // Log sum, its magnitude, ln and its product with T0
   localparam int SW = LOG_W + 2;
   localparam int MW = SW - 1;
   localparam logic [23:0] LN2_Q24 = 24'd11629080;
   localparam int PW = 17 + MW;

   // Denominator
   localparam int D40W = ((56 > PW) ? 56 : PW) + 2;
   localparam int D16W = D40W - 24;

   // Dividend and quotient
   localparam int TBW = 33;
   localparam int NW = TBW + 8 + FRACTION_BITS + 1;
   localparam int TW = NW + 2;
   localparam int OFFSET = ((27315 << FRACTION_BITS) + 50) / 100;

   // Configuration register indexes
   localparam logic [1:0] REG_EXT = 2'd0;
   localparam logic [1:0] REG_REF = 2'd1;
   localparam logic [1:0] REG_T0 = 2'd2;
   localparam logic [1:0] REG_BETA = 2'd3;

   typedef struct packed {
      logic [15:0] high_count;
      logic [15:0] low_count;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature;
      logic invalid;
   } rsp_type;

   typedef struct packed {
      logic [23:0] external_resistance;
      logic [23:0] reference_resistance;
      logic [16:0] reference_temperature;
      logic [15:0] beta_constant;
   } cfg_type;

   // Classified reading handed from front to back
   typedef struct packed {
      logic bad;
      logic [AW-1:0] a;
      logic [AW-1:0] b;
   } work_type;

   // Control traveling beside the back datapath
   typedef struct packed {
      logic valid;
      logic bad;
      logic neg;
   } side_type;

endpackage

/* design/thermistor_beta_temperature.sv */
// Top level of the thermistor beta-equation temperature block.
// Converts converter-chip high/low counts to Celsius with 8 fraction bits.
// Input side is a queue write port: a transaction is taken on a clock edge
// with req_push high and req_full low. Result side is a queue read port: the
// oldest result sits on rsp_data while rsp_empty is low and leaves on an edge
// with rsp_pop high. Every reading gives exactly one result, in order.
// Throughput is one reading per cycle while the reader keeps up. The back
// pipeline is built from the 34-stage log2 pipes (leading-one search, normalize,
// then one squaring per stage) and the 50-stage divider (one quotient bit per stage).
// When the reader stalls, the two-entry result buffer fills, the back
// pipeline holds, the four-entry queue fills and req_full rises.
// Synchronous reset empties all queues and loads the register defaults:
// 10000 ohm series and reference resistors, T0 = 298.15 K, beta = 3950.
// Registers are written through csr_write/csr_index/csr_wdata; the user must
// write them only while no transaction is in flight: the block does not enforce it.
module thermistor_beta_temperature (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tbt_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output tbt_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);

   tbt_pkg::cfg_type cfg_ff;
   logic q_push, q_full, q_pop, q_empty;
   tbt_pkg::work_type q_in, q_head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.external_resistance <= 24'd10000;
         cfg_ff.reference_resistance <= 24'd10000;
         cfg_ff.reference_temperature <= 17'd76326;
         cfg_ff.beta_constant <= 16'd3950;
      end else if (csr_write) begin
         case (csr_index)
            tbt_pkg::REG_EXT: cfg_ff.external_resistance <= csr_wdata;
            tbt_pkg::REG_REF: cfg_ff.reference_resistance <= csr_wdata;
            tbt_pkg::REG_T0: cfg_ff.reference_temperature <= csr_wdata[16:0];
            tbt_pkg::REG_BETA: cfg_ff.beta_constant <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   tbt_front u_front (
      .clock(clock), .reset(reset),
      .req_data(req_data), .req_push(req_push), .req_full(req_full),
      .cfg(cfg_ff), .q_full(q_full), .q_push(q_push), .q_data(q_in));

   tbt_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head));

   tbt_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data));

endmodule

/* design/tbt_front.sv */
// Front end: accepts a reading, forms the resistance terms and flags bad cases.
module tbt_front (
   input  logic              clock,
   input  logic              reset,
   input  tbt_pkg::req_type  req_data,
   input  logic              req_push,
   output logic              req_full,
   input  tbt_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              q_push,
   output tbt_pkg::work_type q_data
);

   logic [tbt_pkg::COUNT_WIDTH-1:0] hi;
   logic [tbt_pkg::COUNT_WIDTH-1:0] lo;
   logic [tbt_pkg::AW-1:0] hi5000;
   logic [tbt_pkg::AW-1:0] lo4999;
   logic advance;
   logic valid_ff, valid_in;
   tbt_pkg::work_type work_ff, work_in;

   assign hi = req_data.high_count[tbt_pkg::COUNT_WIDTH-1:0];
   assign lo = req_data.low_count[tbt_pkg::COUNT_WIDTH-1:0];
   assign hi5000 = tbt_pkg::AW'(hi) * tbt_pkg::AW'(tbt_pkg::K5000);
   assign lo4999 = tbt_pkg::AW'(lo) * tbt_pkg::AW'(tbt_pkg::K4999);

   // Stage moves when empty or when the queue takes its item
   assign advance = !valid_ff || !q_full;
   assign req_full = !advance;
   assign q_push = valid_ff && !q_full;
   assign q_data = work_ff;

   // Classification
   always_comb begin
      work_in.a = hi5000 + tbt_pkg::AW'(lo);
      work_in.b = lo4999 - hi5000;
      work_in.bad = (lo == '0) || (cfg.external_resistance == '0) ||
                    (cfg.reference_resistance == '0) || (hi5000 >= lo4999);
      valid_in = req_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

endmodule

/* design/tbt_queue.sv */
// Four-entry queue between front and back.
module tbt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbt_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tbt_pkg::work_type head
);

   tbt_pkg::work_type mem_ff [0:3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign full = (count_ff == 3'd4);
   assign empty = (count_ff == 3'd0);
   assign head = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/tbt_log2.sv */
// Pipelined log2 in Q32: leading-one search, normalize, then 32 squaring steps.
module tbt_log2 (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [tbt_pkg::LW-1:0]     x,
   output logic [tbt_pkg::LOG_W-1:0]  result
);

   logic [tbt_pkg::KW-1:0] k_find;
   logic [tbt_pkg::KW-1:0] k1_ff;
   logic [tbt_pkg::LW-1:0] x1_ff;
   logic [tbt_pkg::LW-1:0] xn;
   logic [tbt_pkg::KW-1:0] k_ff [0:32];
   logic [31:0] m_ff [0:32];
   logic [31:0] frac_ff [0:32];

   // Index of the top set bit
   always_comb begin
      k_find = '0;
      for (int i = 0; i < tbt_pkg::LW; i++) begin
         if (x[i]) begin
            k_find = tbt_pkg::KW'(i);
         end
      end
   end

   // Left-justify; top 32 bits are the mantissa
   assign xn = x1_ff << (tbt_pkg::LW - 1 - int'(k1_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         k1_ff <= k_find;
         x1_ff <= x;
         k_ff[0] <= k1_ff;
         m_ff[0] <= xn[tbt_pkg::LW-1 -: 32];
         frac_ff[0] <= '0;
      end
   end

   // One fraction bit per stage
   for (genvar g = 0; g < 32; g++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] top;
      assign sq = {32'b0, m_ff[g]} * {32'b0, m_ff[g]};
      assign top = sq[63:31];
      always_ff @(posedge clock) begin
         if (advance) begin
            k_ff[g+1] <= k_ff[g];
            m_ff[g+1] <= top[32] ? top[32:1] : top[31:0];
            frac_ff[g+1] <= {frac_ff[g][30:0], top[32]};
         end
      end
   end

   assign result = {k_ff[32], frac_ff[32]};

endmodule

/* design/tbt_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
module tbt_divider (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [tbt_pkg::NW-1:0]    dividend,
   input  logic [tbt_pkg::D16W-1:0]  divisor,
   output logic [tbt_pkg::NW-1:0]    quotient
);

   localparam int NW = tbt_pkg::NW;
   localparam int DW = tbt_pkg::D16W;

   logic [NW-1:0] n_ff [0:NW];
   logic [DW-1:0] d_ff [0:NW];
   logic [DW-1:0] rem_ff [0:NW];
   logic [NW-1:0] q_ff [0:NW];

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff[0] <= dividend;
         d_ff[0] <= divisor;
         rem_ff[0] <= '0;
         q_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < NW; g++) begin : g_div
      logic [DW:0] trial;
      logic take;
      assign trial = {rem_ff[g], n_ff[g][NW-1-g]};
      assign take = (trial >= {1'b0, d_ff[g]});
      always_ff @(posedge clock) begin
         if (advance) begin
            n_ff[g+1] <= n_ff[g];
            d_ff[g+1] <= d_ff[g];
            rem_ff[g+1] <= take ? DW'(trial - {1'b0, d_ff[g]}) : trial[DW-1:0];
            q_ff[g+1] <= {q_ff[g][NW-2:0], take};
         end
      end
   end

   assign quotient = q_ff[NW];

endmodule

/* design/tbt_back.sv */
// Back end: logs, beta equation, division, saturation and the result buffer.
module tbt_back (
   input  logic              clock,
   input  logic              reset,
   input  tbt_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  tbt_pkg::work_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tbt_pkg::rsp_type  rsp_data
);

   localparam int S_IDX = tbt_pkg::LOG_LAT + 1;
   localparam int L_IDX = S_IDX + 1;
   localparam int P_IDX = L_IDX + 1;
   localparam int D_IDX = P_IDX + 1;
   localparam int LAST = D_IDX + 1 + tbt_pkg::NW;
   localparam int TW = tbt_pkg::TW;
   localparam logic signed [TW-1:0] T_MAX = TW'(8388607);
   localparam logic signed [TW-1:0] T_MIN = -TW'(8388608);
   localparam logic signed [TW-1:0] T_OFF = TW'(tbt_pkg::OFFSET);
   localparam logic [23:0] MINUS_ONE = -24'(1 << tbt_pkg::FRACTION_BITS);

   logic advance;
   tbt_pkg::side_type sb_ff [1:LAST];
   logic [tbt_pkg::LOG_W-1:0] log_ref, log_a, log_ext, log_b;

   logic signed [tbt_pkg::SW-1:0] s;
   logic [tbt_pkg::MW-1:0] mag_ff;
   logic [tbt_pkg::MW+23:0] ln_prod;
   logic [tbt_pkg::MW-1:0] lnmag_ff;
   logic [tbt_pkg::TBW-1:0] tb_l_ff, tb_p_ff, tb_d_ff;
   logic [tbt_pkg::PW-1:0] prod_ff;
   logic signed [tbt_pkg::D40W-1:0] bterm, d40;
   logic signed [tbt_pkg::D16W-1:0] d16;
   logic [tbt_pkg::D16W-1:0] dmag_ff;
   logic [tbt_pkg::NW-1:0] dividend;
   logic [tbt_pkg::NW-1:0] quotient;

   logic signed [TW-1:0] qs, t;
   tbt_pkg::rsp_type result;

   tbt_pkg::rsp_type out_ff [0:1];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   // Whole back pipe moves while the result buffer has room
   assign advance = (count_ff != 2'd2);
   assign q_pop = advance && !q_empty;

   // Control beside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAST; i++) begin
            sb_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         sb_ff[1].valid <= !q_empty;
         for (int i = 2; i <= LAST; i++) begin
            sb_ff[i].valid <= sb_ff[i-1].valid;
         end
      end
   end

   // Sign of the log sum joins at S_IDX; zero check and divisor sign at D_IDX
   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[1].bad <= q_head.bad;
         sb_ff[1].neg <= 1'b0;
         for (int i = 2; i <= LAST; i++) begin
            if (i != D_IDX) begin
               sb_ff[i].bad <= sb_ff[i-1].bad;
            end
            if (i != S_IDX && i != D_IDX) begin
               sb_ff[i].neg <= sb_ff[i-1].neg;
            end
         end
         sb_ff[S_IDX].neg <= s[tbt_pkg::SW-1];
         sb_ff[D_IDX].bad <= sb_ff[P_IDX].bad || (d16 == '0);
         sb_ff[D_IDX].neg <= d16[tbt_pkg::D16W-1];
      end
   end

   // Four logarithms side by side
   tbt_log2 u_log_ref (
      .clock(clock), .advance(advance),
      .x(tbt_pkg::LW'(cfg.reference_resistance)), .result(log_ref));
   tbt_log2 u_log_a (
      .clock(clock), .advance(advance),
      .x(tbt_pkg::LW'(q_head.a)), .result(log_a));
   tbt_log2 u_log_ext (
      .clock(clock), .advance(advance),
      .x(tbt_pkg::LW'(cfg.external_resistance)), .result(log_ext));
   tbt_log2 u_log_b (
      .clock(clock), .advance(advance),
      .x(tbt_pkg::LW'(q_head.b)), .result(log_b));

   // log2 of Rref/R and its magnitude
   assign s = $signed(tbt_pkg::SW'(log_ref)) + $signed(tbt_pkg::SW'(log_a))
            - $signed(tbt_pkg::SW'(log_ext)) - $signed(tbt_pkg::SW'(log_b));

   // ln, T0*ln, T0*B
   assign ln_prod = tbt_pkg::MW'(0) + ({24'b0, mag_ff} * {tbt_pkg::MW'(0), tbt_pkg::LN2_Q24});

   // Denominator B*2^40 -/+ T0*ln, then Q16 by floor
   assign bterm = $signed(tbt_pkg::D40W'({cfg.beta_constant, 40'b0}));
   assign d40 = sb_ff[P_IDX].neg ? bterm + $signed(tbt_pkg::D40W'(prod_ff))
                                 : bterm - $signed(tbt_pkg::D40W'(prod_ff));
   assign d16 = d40[tbt_pkg::D40W-1:24];

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= s[tbt_pkg::SW-1] ? tbt_pkg::MW'(-s) : tbt_pkg::MW'(s);
         lnmag_ff <= ln_prod[tbt_pkg::MW+23:24];
         tb_l_ff <= tbt_pkg::TBW'({16'b0, cfg.reference_temperature} *
                                  {17'b0, cfg.beta_constant});
         prod_ff <= {tbt_pkg::MW'(0), cfg.reference_temperature} *
                    {17'b0, lnmag_ff};
         tb_p_ff <= tb_l_ff;
         dmag_ff <= d16[tbt_pkg::D16W-1] ? tbt_pkg::D16W'(-d16) : tbt_pkg::D16W'(d16);
         tb_d_ff <= tb_p_ff;
      end
   end

   // Rounded quotient T0*B*2^(8+F) / |D16|
   assign dividend = tbt_pkg::NW'({tb_d_ff, {(8 + tbt_pkg::FRACTION_BITS){1'b0}}})
                   + tbt_pkg::NW'(dmag_ff >> 1);

   tbt_divider u_div (
      .clock(clock), .advance(advance),
      .dividend(dividend), .divisor(dmag_ff), .quotient(quotient));

   // Sign, Kelvin offset, saturation
   always_comb begin
      qs = $signed(TW'(quotient));
      t = (sb_ff[LAST].neg ? -qs : qs) - T_OFF;
      if (sb_ff[LAST].bad) begin
         result.temperature = MINUS_ONE;
         result.invalid = 1'b1;
      end else begin
         result.invalid = 1'b0;
         if (t > T_MAX) begin
            result.temperature = T_MAX[23:0];
         end else if (t < T_MIN) begin
            result.temperature = T_MIN[23:0];
         end else begin
            result.temperature = t[23:0];
         end
      end
   end

   // Two-entry result buffer
   assign push = advance && sb_ff[LAST].valid;
   assign pop = rsp_pop && !rsp_empty;
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data = out_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the thermistor beta-equation temperature block.
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_COUNT = 1600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   tbt_pkg::req_type req_data = '0;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   tbt_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = tbt_pkg::REG_EXT;
   logic [23:0] csr_wdata = '0;

   thermistor_beta_temperature dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Local copy of the register file
   logic [23:0] ext_ohms;
   logic [23:0] ref_ohms;
   logic [16:0] t0_kelvin;
   logic [15:0] beta_k;

   tbt_pkg::rsp_type expected_temps[$];
   int errors = 0;
   int checked = 0;
   int idle_cycles = 0;
   bit hold_reader = 1'b0;
   bit stimulus_done = 1'b0;

   // log2 in Q32 by repeated squaring of the normalized mantissa
   function automatic logic [63:0] log2_fixed(input logic [63:0] x);
      int top;
      logic [127:0] m;
      logic [31:0] frac;
      top = 0;
      frac = '0;
      for (int i = 0; i < 64; i++)
         if (x[i]) top = i;
      if (top >= 31) m = x >> (top - 31);
      else m = x << (31 - top);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 128'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {top[31:0], frac};
   endfunction

   // Celsius from one reading under the current registers
   function automatic tbt_pkg::rsp_type celsius_of(input tbt_pkg::req_type rd);
      tbt_pkg::rsp_type r;
      logic [63:0] hi, lo, a, b, mag, lnmag, prod, num, dmag, q;
      logic signed [63:0] s, d40, d16, t;
      logic signed [63:0] offset;
      hi = rd.high_count;
      lo = rd.low_count;
      offset = tbt_pkg::OFFSET;
      r.temperature = -(24'sd1 <<< tbt_pkg::FRACTION_BITS);
      r.invalid = 1'b1;
      if (lo == 0 || ext_ohms == 0 || ref_ohms == 0 || 5000 * hi >= 4999 * lo)
         return r;
      a = 5000 * hi + lo;
      b = 4999 * lo - 5000 * hi;
      s = $signed(log2_fixed(ref_ohms)) + $signed(log2_fixed(a))
        - $signed(log2_fixed(ext_ohms)) - $signed(log2_fixed(b));
      mag = (s < 0) ? -s : s;
      lnmag = (mag * 64'd11629080) >> 24;
      prod = t0_kelvin * lnmag;
      d40 = $signed({8'd0, beta_k, 40'd0});
      if (s < 0) d40 = d40 + $signed(prod);
      else d40 = d40 - $signed(prod);
      if (d40 >= 0) d16 = d40 >>> 24;
      else d16 = -$signed((64'(-d40) + 64'hFFFFFF) >> 24);
      if (d16 == 0) return r;
      num = (64'(t0_kelvin) * beta_k) << (8 + tbt_pkg::FRACTION_BITS);
      dmag = (d16 < 0) ? -d16 : d16;
      q = (num + dmag / 2) / dmag;
      t = (d16 < 0) ? -$signed(q) : $signed(q);
      t = t - offset;
      if (t > 8388607) t = 8388607;
      if (t < -8388608) t = -8388608;
      r.temperature = t[23:0];
      r.invalid = 1'b0;
      return r;
   endfunction

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Result side: stall pattern, check, watchdog
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            checked++;
            if (expected_temps.size() == 0) begin
               report("unexpected result", rsp_data.temperature, 0);
            end else begin
               if (rsp_data.temperature !== expected_temps[0].temperature)
                  report("temperature", rsp_data.temperature,
                         expected_temps[0].temperature);
               if (rsp_data.invalid !== expected_temps[0].invalid)
                  report("invalid flag", rsp_data.invalid, expected_temps[0].invalid);
               void'(expected_temps.pop_front());
            end
         end
         if ((rsp_pop && !rsp_empty) || (req_push && !req_full)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_temps.size());
            $display("thermistor_beta_temperature test failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 29;
      if (hold_reader) rsp_pop <= 1'b0;
      else if (stall_phase < 10) rsp_pop <= 1'b1;
      else rsp_pop <= ($urandom_range(0, 3) != 0);
   end

   // Register write at a falling edge, idle only
   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         tbt_pkg::REG_EXT: ext_ohms = val;
         tbt_pkg::REG_REF: ref_ohms = val;
         tbt_pkg::REG_T0: t0_kelvin = val[16:0];
         tbt_pkg::REG_BETA: beta_k = val[15:0];
         default: ;
      endcase
   endtask

   // Offer one reading, hold until accepted; expectation queued on acceptance
   task automatic send_reading(input tbt_pkg::req_type rd);
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= rd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_temps.push_back(celsius_of(rd));
   endtask

   task automatic release_sender();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic wait_drained();
      release_sender();
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic tbt_pkg::req_type random_reading();
      tbt_pkg::req_type rd;
      logic [31:0] lo;
      case ($urandom_range(0, 9))
         0: rd = {16'($urandom), 16'($urandom)};
         1: rd = {16'($urandom), 16'd0};
         default: begin
            lo = $urandom_range(1, 65535);
            rd.low_count = lo[15:0];
            rd.high_count = 16'($urandom_range(0, (4999 * lo) / 5000));
         end
      endcase
      return rd;
   endfunction

   typedef struct {
      tbt_pkg::req_type rd;
      bit known;
      tbt_pkg::rsp_type want;
   } step_type;

   step_type directed[] = '{
      '{ {16'd0, 16'd0}, 1'b1, {-24'sd256, 1'b1} },
      '{ {16'hFFFF, 16'd0}, 1'b1, {-24'sd256, 1'b1} },
      '{ {16'hFFFF, 16'hFFFF}, 1'b1, {-24'sd256, 1'b1} },
      '{ {16'd4999, 16'd5000}, 1'b1, {-24'sd256, 1'b1} },
      '{ {16'd0, 16'd1}, 1'b0, '0 },
      '{ {16'd0, 16'hFFFF}, 1'b0, '0 },
      '{ {16'd1000, 16'd2000}, 1'b0, '0 },
      '{ {16'd3000, 16'd5000}, 1'b0, '0 },
      '{ {16'h5555, 16'hAAAA}, 1'b0, '0 },
      '{ {16'd4998, 16'd5000}, 1'b0, '0 },
      '{ {16'd1, 16'hFFFF}, 1'b0, '0 },
      '{ {16'h7FFF, 16'hFFFF}, 1'b0, '0 }
   };

   // One pass of random readings in bursts with gaps
   task automatic random_phase(input int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_reading(random_reading());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            release_sender();
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   endtask

   logic [23:0] settings[5][4] = '{
      '{24'd10000, 24'd10000, 24'd76326, 24'd3950},
      '{24'hFFFFFF, 24'd1, 24'd131071, 24'd65535},
      '{24'd1, 24'hFFFFFF, 24'd0, 24'd0},
      '{24'd0, 24'd0, 24'd1, 24'd1},
      '{24'd4700, 24'd100000, 24'd70000, 24'd3435}
   };

   initial begin
      ext_ohms = 24'd10000;
      ref_ohms = 24'd10000;
      t0_kelvin = 17'd76326;
      beta_k = 16'd3950;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at reset defaults
      foreach (directed[i]) begin
         send_reading(directed[i].rd);
         if (directed[i].known) begin
            if (directed[i].want !== expected_temps[$])
               report("predictor table row", expected_temps[$].temperature,
                      directed[i].want.temperature);
         end
      end
      wait_drained();

      // Long reader stall while the sender keeps pushing past the block's depth
      hold_reader = 1'b1;
      fork
         begin
            for (int i = 0; i < 150; i++) send_reading(random_reading());
            release_sender();
         end
         begin
            repeat (300) @(posedge clock);
            hold_reader = 1'b0;
         end
      join
      wait_drained();

      // Register settings, extremes among them
      for (int s = 0; s < 5; s++) begin
         for (int r = 0; r < 4; r++) write_reg(r[1:0], settings[s][r]);
         random_phase(s == 0 ? RANDOM_COUNT / 2 : RANDOM_COUNT / 8);
         wait_drained();
      end
      for (int r = 0; r < 4; r++) write_reg(r[1:0], settings[0][r]);
      random_phase(RANDOM_COUNT / 8);
      wait_drained();

      $display("covered directed corner readings, a full-queue stall and %0d results", checked);
      $display("across five register settings including all-ones and zero registers");
      if (errors == 0) begin
         $display("thermistor_beta_temperature test passed");
      end else begin
         $display("thermistor_beta_temperature test failed");
      end
      $finish;
   end

endmodule
